[design/lz78_pkg.sv]
// Package for the LZ78 phrase encoder: sizes, hash function and shared types.
// Used by lz78_dict and lz78_encoder; depends on nothing.
`default_nettype none
package lz78_pkg;
    localparam int DictEntries = 4096;
    localparam int TableSlots  = 8192;
    localparam int CodeW       = 13;
    localparam int SlotW       = $clog2(TableSlots);
    localparam int KeyW        = CodeW + 8;
    localparam int EpochW      = 8;
    localparam int CntW        = $clog2(DictEntries + 1);

    // Hash of the key, taken as a 32-bit value like the model does.
    function automatic logic [SlotW-1:0] home_slot(input logic [31:0] key);
        logic [31:0] h;
        h = key * 32'h9E3779B1;
        h = h ^ (h >> 15);
        return h[SlotW-1:0];
    endfunction

    // One table entry: epoch tag (valid when equal to the current epoch),
    // key and stored index.
    typedef struct packed {
        logic [EpochW-1:0] epoch;
        logic [KeyW-1:0]   key;
        logic [CodeW-1:0]  value;
    } t_entry;
endpackage
`default_nettype wire

[design/lz78_dict.sv]
// Dictionary memory of the LZ78 encoder: one read port, one write port,
// registered read data. Uses lz78_pkg for the entry type.
`default_nettype none
module lz78_dict (
    input  wire                            i_clk,
    input  wire                            i_rd_en,
    input  wire [lz78_pkg::SlotW-1:0]      i_rd_addr,
    output lz78_pkg::t_entry               o_rd_data,
    input  wire                            i_wr_en,
    input  wire [lz78_pkg::SlotW-1:0]      i_wr_addr,
    input  lz78_pkg::t_entry               i_wr_data
);
    lz78_pkg::t_entry mem [lz78_pkg::TableSlots];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

[design/lz78_encoder.sv]
// Top level of the LZ78 phrase encoder: probe sequencer and output register.
// Depends on lz78_pkg and lz78_dict.
//
// Usage. Bytes arrive on the slave stream (tdata = symbol, tlast = final
// byte). Each byte is looked up in a hashed dictionary, held in one
// synchronous memory, by linear probing from its home slot. A hit extends the
// pending phrase and gives no transfer; a miss inserts the new phrase and
// gives one result on the master stream: tdata = {tail_byte, prefix_index},
// tuser = prefix flag, tlast = stream_end. The final byte always gives a
// result and starts a new stream.
// Sequence: the accepting cycle issues the read of the home slot and each
// following cycle checks one slot. A hit at the home slot returns to idle
// after that check; a miss, or a final byte, goes on to an emit step that
// loads the output register, which then presents the result. Every further
// probed slot adds one more check. The single memory read port is why slots
// are checked one at a time.
// Clearing the dictionary (when full or after the final byte) costs nothing:
// entries carry an epoch tag and a clear bumps the epoch. Once in 255 clears
// a sweep rewrites every tag, during which no byte is taken. After reset the
// block first runs that sweep, then is ready. A held result waits in the
// output register; the next byte is accepted meanwhile and its processing
// stalls only if it must emit while the output register is still full.
`default_nettype none
module lz78_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] symbol
    input  wire         s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [12:0] prefix_index, [20:13] tail_byte
    output logic        m_axis_tuser,   // prefix flag
    output logic        m_axis_tlast    // stream_end
);
    localparam int SlotW  = lz78_pkg::SlotW;
    localparam int CodeW  = lz78_pkg::CodeW;
    localparam int EpochW = lz78_pkg::EpochW;
    localparam int CntW   = lz78_pkg::CntW;

    typedef enum logic [3:0] {
        ST_SWEEP = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_PROBE = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [SlotW-1:0]        r_sweep, n_sweep;
    logic [EpochW-1:0]       r_epoch, n_epoch;
    logic [CntW-1:0]         r_count, n_count;
    logic [CodeW-1:0]        r_phrase, n_phrase;
    logic [SlotW-1:0]        r_slot, n_slot;
    logic [SlotW:0]          r_tries, n_tries;
    logic [7:0]              r_sym, n_sym;
    logic                    r_fin, n_fin;
    logic                    r_ovalid, n_ovalid;
    logic [23:0]             r_odata, n_odata;
    logic                    r_ouser, n_ouser;
    logic                    r_olast, n_olast;

    logic                    rd_en, wr_en;
    logic [SlotW-1:0]        rd_addr, wr_addr;
    lz78_pkg::t_entry        rd_data, wr_data;
    logic [lz78_pkg::KeyW-1:0] key;
    logic                    slot_valid, hit;

    lz78_dict u_dict (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign key        = {r_phrase, r_sym};
    assign slot_valid = (rd_data.epoch == r_epoch);
    assign hit        = slot_valid && (rd_data.key == key);

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_epoch  = r_epoch;
        n_count  = r_count;
        n_phrase = r_phrase;
        n_slot   = r_slot;
        n_tries  = r_tries;
        n_sym    = r_sym;
        n_fin    = r_fin;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        rd_en    = 1'b0;
        rd_addr  = r_slot;
        wr_en    = 1'b0;
        wr_addr  = r_slot;
        wr_data  = '{epoch: r_epoch, key: key,
                     value: (CodeW)'(r_count + CntW'(1))};
        s_axis_tready = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                // Epoch tags are rewritten to a value that never matches
                // the current epoch.
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                wr_data = '{epoch: r_epoch - EpochW'(1), key: '0, value: '0};
                n_sweep = r_sweep + SlotW'(1);
                if (r_sweep == SlotW'(lz78_pkg::TableSlots - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_sym = s_axis_tdata;
                    n_fin = s_axis_tlast;
                    n_slot  = lz78_pkg::home_slot(32'({r_phrase, s_axis_tdata}));
                    n_tries = '0;
                    n_state = ST_PROBE;
                    rd_en   = 1'b1;
                    rd_addr = n_slot;
                end
            end
            ST_PROBE: begin
                // Data for r_slot is available this cycle.
                if (hit) begin
                    if (r_fin) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_phrase = rd_data.value;
                        n_state  = ST_IDLE;
                    end
                end else if (!slot_valid ||
                             r_tries == (SlotW+1)'(lz78_pkg::TableSlots - 1)) begin
                    wr_en   = !slot_valid;
                    n_count = r_count + CntW'(1);
                    n_state = ST_EMIT;
                end else begin
                    n_slot  = r_slot + SlotW'(1);
                    n_tries = r_tries + (SlotW+1)'(1);
                    rd_en   = 1'b1;
                    rd_addr = n_slot;
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {3'b000, r_sym, r_phrase};
                    n_ouser  = (r_phrase != '0);
                    n_olast  = r_fin;
                    n_phrase = '0;
                    n_state  = ST_IDLE;
                    // The counter only grows on a miss, so a full dictionary
                    // is cleared here, before the next byte is taken.
                    if (r_fin || r_count == CntW'(lz78_pkg::DictEntries)) begin
                        n_count = '0;
                        n_epoch = r_epoch + EpochW'(1);
                    end
                end
            end
            default: n_state = ST_SWEEP;
        endcase
        // Epoch wrap: old tags could match again, so sweep first.
        if (r_state != ST_SWEEP && n_epoch != r_epoch && n_epoch == '1) begin
            n_state = (n_state == ST_IDLE) ? ST_SWEEP : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SWEEP;
            r_sweep  <= '0;
            r_epoch  <= '0;
            r_count  <= '0;
            r_phrase <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_epoch  <= (n_epoch == '1) ? '0 : n_epoch;
            r_count  <= n_count;
            r_phrase <= n_phrase;
            r_ovalid <= n_ovalid;
        end
        r_slot  <= n_slot;
        r_tries <= n_tries;
        r_sym   <= n_sym;
        r_fin   <= n_fin;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // A result held under backpressure must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_odata))
        else $error("output changed while stalled");
    // Index counter never exceeds the dictionary size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(lz78_pkg::DictEntries))
        else $error("entry counter overflow");
    // A literal result never carries a nonzero prefix flag.
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ouser == (r_odata[12:0] != 13'd0)))
        else $error("prefix flag inconsistent with prefix index");
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for lz78_encoder: directed byte table, then random streams.
// Depends on lz78_pkg and lz78_encoder; expected phrases come from an in-bench model.
`timescale 1ns / 1ps
module tb_top;

    // One expected (or observed) phrase transfer on the master stream.
    typedef struct packed {
        logic                       prefix_flag;
        logic [lz78_pkg::CodeW-1:0] prefix_index;
        logic [7:0]                 tail_byte;
        logic                       stream_end;
    } t_phrase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] symbol
    logic        s_axis_tlast = 1'b0;   // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [12:0] prefix_index, [20:13] tail_byte
    logic        m_axis_tuser;          // prefix flag
    logic        m_axis_tlast;          // stream_end

    lz78_encoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of the encoder state: pending phrase, index counter, hash table.
    logic [31:0]   cur_phrase;
    logic [31:0]   next_index;
    bit            slot_used [lz78_pkg::TableSlots];
    logic [31:0]   slot_key  [lz78_pkg::TableSlots];
    logic [31:0]   slot_index[lz78_pkg::TableSlots];
    t_phrase       pending_phrases[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            sent_count = 0;
    bit            hold_off = 1'b0;
    bit            calm = 1'b0;

    function automatic logic [31:0] bench_hash(logic [31:0] key);
        logic [31:0] h;
        h = key * 32'h9E3779B1;
        h = h ^ (h >> 15);
        return h % lz78_pkg::TableSlots;
    endfunction

    function automatic void wipe_dictionary();
        foreach (slot_used[k]) slot_used[k] = 1'b0;
        next_index = 0;
    endfunction

    // Advance the bench model by one byte and queue the phrase it emits, if any.
    function automatic void encode_byte(logic [7:0] sym, logic last);
        logic [31:0] key, found, slot, free_slot;
        bit          hit, stop;
        t_phrase     p;
        if (next_index >= lz78_pkg::DictEntries) wipe_dictionary();
        key = (cur_phrase << 8) | sym;
        slot = bench_hash(key);
        free_slot = lz78_pkg::TableSlots;
        hit = 1'b0;
        stop = 1'b0;
        found = 0;
        for (int n = 0; n < lz78_pkg::TableSlots && !stop; n++) begin
            if (!slot_used[slot]) begin
                free_slot = slot;
                stop = 1'b1;
            end else if (slot_key[slot] == key) begin
                found = slot_index[slot];
                hit = 1'b1;
                stop = 1'b1;
            end else begin
                slot = (slot + 1) % lz78_pkg::TableSlots;
            end
        end
        if (!hit) begin
            next_index++;
            if (free_slot < lz78_pkg::TableSlots) begin
                slot_used[free_slot] = 1'b1;
                slot_key[free_slot] = key;
                slot_index[free_slot] = next_index;
            end
        end
        if (!hit || last) begin
            p.prefix_flag = (cur_phrase != 0);
            p.prefix_index = cur_phrase[lz78_pkg::CodeW-1:0];
            p.tail_byte = sym;
            p.stream_end = last;
            pending_phrases = {pending_phrases, p};
        end
        cur_phrase = (hit && !last) ? found : 0;
        if (last) wipe_dictionary();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Drive one byte, model it, and wait for its transfer; random idle gaps first.
    task automatic send_byte(logic [7:0] sym, logic last);
        while (!calm && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sym;
        s_axis_tlast <= last;
        encode_byte(sym, last);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Directed table. The first rows are a fresh stream whose phrases are read off
    // at a glance: "AA" repeats give literal A, then (1,A) and so on.
    typedef struct {
        logic [7:0] sym;
        logic       last;
        bit         known;
        t_phrase    want;
    } t_row;
    t_row dir_rows[$];

    function automatic t_row mk(logic [7:0] s, logic l, bit k = 0,
                                logic m = 0, int pi = 0, logic e = 0);
        t_row r;
        r.sym = s; r.last = l; r.known = k;
        r.want.prefix_flag = m; r.want.prefix_index = pi[lz78_pkg::CodeW-1:0];
        r.want.tail_byte = s; r.want.stream_end = e;
        return r;
    endfunction

    function automatic void add_row(logic [7:0] s, logic l, bit k = 0,
                                    logic m = 0, int pi = 0, logic e = 0);
        dir_rows = {dir_rows, mk(s, l, k, m, pi, e)};
    endfunction

    initial begin
        // Literal 0x41 -> index 1, hit on 0x41 then miss 0x41 -> (1, 0x41) index 2.
        add_row(8'h41, 0, 1, 0, 0, 0);
        add_row(8'h41, 0);
        add_row(8'h41, 0, 1, 1, 1, 0);
        add_row(8'h00, 0, 1, 0, 0, 0);
        add_row(8'hFF, 0, 1, 0, 0, 0);
        add_row(8'hFF, 0);
        add_row(8'h00, 0, 1, 1, 4, 0);
        // Final byte during a pending phrase flushes with stream_end.
        add_row(8'h41, 0);
        add_row(8'h41, 0);
        add_row(8'h80, 1, 1, 1, 2, 1);
        // One-byte stream, then final byte that would have hit.
        add_row(8'h7F, 1, 1, 0, 0, 1);
        add_row(8'h55, 0, 1, 0, 0, 0);
        add_row(8'h55, 1, 1, 0, 0, 1);
        add_row(8'hAA, 0);
        add_row(8'h01, 0);
        add_row(8'hAA, 0);
        add_row(8'h01, 1);
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 28);
        end
    end

    // Each accepted phrase is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_phrase want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_phrases.size() == 0) begin
                report_mismatch("unexpected phrase, tdata", m_axis_tdata, 0);
            end else begin
                want = pending_phrases.pop_front();
                if (m_axis_tuser !== want.prefix_flag)
                    report_mismatch("prefix flag", m_axis_tuser, want.prefix_flag);
                if (m_axis_tdata[12:0] !== want.prefix_index)
                    report_mismatch("prefix_index", m_axis_tdata[12:0], want.prefix_index);
                if (m_axis_tdata[20:13] !== want.tail_byte)
                    report_mismatch("tail_byte", m_axis_tdata[20:13], want.tail_byte);
                if (m_axis_tlast !== want.stream_end)
                    report_mismatch("stream_end", m_axis_tlast, want.stream_end);
            end
        end
    end

    // Run limit: the clearing sweeps plus slow handshakes, many times over.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process, while bytes keep coming.
    initial begin
        wait (sent_count >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int   stream_len;
        logic [7:0] alpha;
        logic [7:0] sym_r;
        cur_phrase = 0;
        wipe_dictionary();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].known) begin
                // Typed-in row: the model must agree with the table.
                send_byte(dir_rows[r].sym, dir_rows[r].last);
                if (pending_phrases.size() == 0 ||
                        pending_phrases[$] !== dir_rows[r].want)
                    report_mismatch("directed row", r, 0);
            end else begin
                send_byte(dir_rows[r].sym, dir_rows[r].last);
            end
        end

        // Random streams: mostly narrow alphabets so phrases grow long, some noise.
        while (sent_count < 1500) begin
            stream_len = $urandom_range(1, 120);
            alpha = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(1, 6));
            calm = (sent_count > 900 && sent_count < 1100);
            for (int k = 0; k < stream_len; k++) begin
                if (alpha == 8'hFF)
                    sym_r = 8'($urandom);
                else
                    sym_r = 8'($urandom_range(0, alpha)) ^
                            8'($urandom_range(1) * 8'hF0);
                send_byte(sym_r, (k == stream_len - 1) && ($urandom_range(3) != 0));
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        wait (pending_phrases.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
